// ===== rtl/cwu_pkg.sv =====
// ----------------------------------------------------------------------------
// cwu_pkg
// Shared types, constants and helper functions of the clip window unit.
// ----------------------------------------------------------------------------
package cwu_pkg;

   localparam int CoordWidth = 16;
   localparam int CsrWidth   = 15;
   localparam int QuoWidth   = 17;
   localparam int EdgeCount  = 4;
   localparam int DivLat     = QuoWidth;
   localparam int BackLat    = 3;
   localparam int TotalLat   = 1 + DivLat + BackLat;

   localparam logic [CsrWidth-1:0] ScreenMaxX = 15'd1023;
   localparam logic [CsrWidth-1:0] ScreenMaxY = 15'd1023;
   localparam logic [QuoWidth-1:0] OneFix     = 17'h10000;

   typedef enum logic [2:0] {
      REQ_POINT = 3'd0,
      REQ_HLINE = 3'd1,
      REQ_VLINE = 3'd2,
      REQ_LINE  = 3'd3,
      REQ_RECT  = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      CSR_LEFT   = 2'd0,
      CSR_TOP    = 2'd1,
      CSR_RIGHT  = 2'd2,
      CSR_BOTTOM = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      EDGE_NONE   = 2'd0,
      EDGE_LOWER  = 2'd1,
      EDGE_UPPER  = 2'd2,
      EDGE_REJECT = 2'd3
   } edge_kind_type;

   typedef struct packed {
      logic [CsrWidth-1:0] left;
      logic [CsrWidth-1:0] top;
      logic [CsrWidth-1:0] right;
      logic [CsrWidth-1:0] bottom;
   } window_type;

   typedef struct packed {
      logic                         is_line;
      logic                         triv_rej;
      logic                         vis;
      logic signed [CoordWidth-1:0] xa;
      logic signed [CoordWidth-1:0] ya;
      logic signed [CoordWidth-1:0] xb;
      logic signed [CoordWidth-1:0] yb;
      logic signed [CoordWidth-1:0] sxa;
      logic signed [CoordWidth-1:0] sya;
      logic signed [CoordWidth-1:0] sxb;
      logic signed [CoordWidth-1:0] syb;
      logic signed [CoordWidth-1:0] dx;
      logic signed [CoordWidth-1:0] dy;
      edge_kind_type [EdgeCount-1:0] kind;
   } item_type;

   typedef struct packed {
      logic                         vis;
      logic signed [CoordWidth-1:0] lo;
      logic signed [CoordWidth-1:0] hi;
   } span_type;

   function automatic logic signed [CoordWidth-1:0] edge_val(input logic [CsrWidth-1:0] e);
      return $signed({1'b0, e});
   endfunction

   function automatic logic in_range(input logic signed [CoordWidth-1:0] v,
                                     input logic [CsrWidth-1:0] lo_edge,
                                     input logic [CsrWidth-1:0] hi_edge);
      return (v >= edge_val(lo_edge)) && (v <= edge_val(hi_edge));
   endfunction

   function automatic span_type clip_span(input logic signed [CoordWidth-1:0] a,
                                          input logic signed [CoordWidth-1:0] b,
                                          input logic [CsrWidth-1:0] lo_edge,
                                          input logic [CsrWidth-1:0] hi_edge);
      span_type s;
      s.lo = (a > b) ? b : a;
      s.hi = (a > b) ? a : b;
      if (s.lo < edge_val(lo_edge)) begin
         s.lo = edge_val(lo_edge);
      end
      if (s.hi > edge_val(hi_edge)) begin
         s.hi = edge_val(hi_edge);
      end
      s.vis = (s.lo <= s.hi);
      return s;
   endfunction

endpackage

// ===== rtl/cwu_div_lane.sv =====
// ----------------------------------------------------------------------------
// cwu_div_lane
// Pipelined restoring divider: floor(num * 2^16 / den), one quotient bit per
// stage, with a flag for quotients of 2^17 and above.
// ----------------------------------------------------------------------------
module cwu_div_lane (
   input  logic                                 clock,
   input  logic [cwu_pkg::CoordWidth-1:0]       num,
   input  logic [cwu_pkg::CoordWidth-1:0]       den,
   output logic [cwu_pkg::QuoWidth-1:0]         quo,
   output logic                                 big
);
   import cwu_pkg::*;

   logic [CoordWidth-1:0] rem_ff [DivLat];
   logic [CoordWidth-1:0] den_ff [DivLat];
   logic [QuoWidth-1:0]   quo_ff [DivLat];
   logic                  big_ff [DivLat];

   genvar i;
   generate
      for (i = 0; i < DivLat; i++) begin : g_stage
         logic [QuoWidth-1:0]   cand;
         logic [QuoWidth-1:0]   diff;
         logic [CoordWidth-1:0] den_cur;
         logic [QuoWidth-1:0]   quo_prev;
         logic                  big_cur;
         logic                  ge;
         logic [CoordWidth-1:0] rem_in;
         logic [QuoWidth-1:0]   quo_in;

         if (i == 0) begin : g_first
            assign cand     = {1'b0, num};
            assign den_cur  = den;
            assign quo_prev = '0;
            assign big_cur  = ({1'b0, num} >= {den, 1'b0});
         end else begin : g_next
            assign cand     = {rem_ff[i-1], 1'b0};
            assign den_cur  = den_ff[i-1];
            assign quo_prev = quo_ff[i-1];
            assign big_cur  = big_ff[i-1];
         end

         always_comb begin
            ge     = (cand >= {1'b0, den_cur});
            diff   = cand - {1'b0, den_cur};
            rem_in = ge ? diff[CoordWidth-1:0] : cand[CoordWidth-1:0];
            quo_in = quo_prev;
            quo_in[QuoWidth-1-i] = ge;
         end

         always_ff @(posedge clock) begin
            rem_ff[i] <= rem_in;
            den_ff[i] <= den_cur;
            quo_ff[i] <= quo_in;
            big_ff[i] <= big_cur;
         end
      end
   endgenerate

   assign quo = quo_ff[DivLat-1];
   assign big = big_ff[DivLat-1];

endmodule

// ===== rtl/cwu_front.sv =====
// ----------------------------------------------------------------------------
// cwu_front
// Entry stage: simple primitive clipping, trivial reject, line deltas and
// edge classification with divider operands.
// ----------------------------------------------------------------------------
module cwu_front (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   input  logic [2:0]                                    req_type,
   input  logic signed [cwu_pkg::CoordWidth-1:0]         xa,
   input  logic signed [cwu_pkg::CoordWidth-1:0]         ya,
   input  logic signed [cwu_pkg::CoordWidth-1:0]         xb,
   input  logic signed [cwu_pkg::CoordWidth-1:0]         yb,
   input  cwu_pkg::window_type                           win,
   output logic                                          valid_ff,
   output cwu_pkg::item_type                             item_ff,
   output logic [cwu_pkg::EdgeCount-1:0][cwu_pkg::CoordWidth-1:0] num_ff,
   output logic [cwu_pkg::EdgeCount-1:0][cwu_pkg::CoordWidth-1:0] den_ff
);
   import cwu_pkg::*;

   item_type item_in;
   logic [EdgeCount-1:0][CoordWidth-1:0] num_in;
   logic [EdgeCount-1:0][CoordWidth-1:0] den_in;
   logic upper_ok;

   always_comb begin
      logic signed [CoordWidth-1:0] p [EdgeCount];
      logic signed [CoordWidth-1:0] q [EdgeCount];
      logic [CoordWidth-1:0] pm;
      logic [CoordWidth-1:0] qm;
      span_type sx;
      span_type sy;

      item_in = '0;
      item_in.xa  = xa;
      item_in.ya  = ya;
      item_in.xb  = xb;
      item_in.yb  = yb;
      item_in.sxa = xa;
      item_in.sya = ya;
      item_in.sxb = xb;
      item_in.syb = yb;
      item_in.dx  = xb - xa;
      item_in.dy  = yb - ya;
      item_in.is_line = (req_type == REQ_LINE);
      item_in.triv_rej = ((xa < edge_val(win.left))   && (xb < edge_val(win.left)))  ||
                         ((xa > edge_val(win.right))  && (xb > edge_val(win.right))) ||
                         ((ya < edge_val(win.top))    && (yb < edge_val(win.top)))   ||
                         ((ya > edge_val(win.bottom)) && (yb > edge_val(win.bottom)));

      sx = clip_span(xa, xb, win.left, win.right);
      sy = clip_span(ya, yb, win.top, win.bottom);

      case (req_type)
         REQ_POINT: begin
            item_in.vis = in_range(xa, win.left, win.right) &&
                          in_range(ya, win.top, win.bottom);
         end
         REQ_HLINE: begin
            if (in_range(ya, win.top, win.bottom)) begin
               item_in.vis = sx.vis;
               item_in.sxa = sx.lo;
               item_in.sxb = sx.hi;
            end
         end
         REQ_VLINE: begin
            if (in_range(xa, win.left, win.right)) begin
               item_in.vis = sy.vis;
               item_in.sya = sy.lo;
               item_in.syb = sy.hi;
            end
         end
         REQ_RECT: begin
            item_in.vis = sx.vis && sy.vis;
            item_in.sxa = sx.lo;
            item_in.sxb = sx.hi;
            item_in.sya = sy.lo;
            item_in.syb = sy.hi;
         end
         default: begin
            item_in.vis = 1'b0;
         end
      endcase

      p[0] = -item_in.dx;
      q[0] = xa - edge_val(win.left);
      p[1] = item_in.dx;
      q[1] = edge_val(win.right) - xa;
      p[2] = -item_in.dy;
      q[2] = ya - edge_val(win.top);
      p[3] = item_in.dy;
      q[3] = edge_val(win.bottom) - ya;

      for (int e = 0; e < EdgeCount; e++) begin
         pm = p[e][CoordWidth-1] ? -p[e] : p[e];
         qm = q[e][CoordWidth-1] ? -q[e] : q[e];
         num_in[e] = qm;
         den_in[e] = pm;
         if (p[e] < 0) begin
            if ((q[e] < 0) && !((qm == 16'h8000) && (pm == 16'd1))) begin
               item_in.kind[e] = EDGE_LOWER;
            end else begin
               item_in.kind[e] = EDGE_NONE;
            end
         end else if (p[e] > 0) begin
            if (q[e] < 0) begin
               item_in.kind[e] = EDGE_REJECT;
            end else if (q[e] < p[e]) begin
               item_in.kind[e] = EDGE_UPPER;
            end else begin
               item_in.kind[e] = EDGE_NONE;
            end
         end else begin
            item_in.kind[e] = (q[e] < 0) ? EDGE_REJECT : EDGE_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
   end

   always_comb begin
      upper_ok = 1'b1;
      for (int e = 0; e < EdgeCount; e++) begin
         if ((item_ff.kind[e] == EDGE_UPPER) && (num_ff[e] >= den_ff[e])) begin
            upper_ok = 1'b0;
         end
      end
   end

   a_upper_below_one: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> upper_ok)
      else $error("upper edge ratio not below one");

endmodule

// ===== rtl/cwu_back.sv =====
// ----------------------------------------------------------------------------
// cwu_back
// Parameter merge, endpoint products and final endpoint selection.
// ----------------------------------------------------------------------------
module cwu_back (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   input  cwu_pkg::item_type                             item,
   input  logic [cwu_pkg::EdgeCount-1:0][cwu_pkg::QuoWidth-1:0] quo,
   input  logic [cwu_pkg::EdgeCount-1:0]                 big,
   input  cwu_pkg::window_type                           win,
   output logic                                          rsp_valid,
   output logic                                          rsp_visible,
   output logic signed [cwu_pkg::CoordWidth-1:0]         rsp_xa_out,
   output logic signed [cwu_pkg::CoordWidth-1:0]         rsp_ya_out,
   output logic signed [cwu_pkg::CoordWidth-1:0]         rsp_xb_out,
   output logic signed [cwu_pkg::CoordWidth-1:0]         rsp_yb_out
);
   import cwu_pkg::*;

   logic                t1_valid_ff;
   item_type            t1_item_ff;
   logic [QuoWidth-1:0] lo_t_ff;
   logic [QuoWidth-1:0] hi_t_ff;
   logic                rej_ff;
   logic [QuoWidth-1:0] lo_t_in;
   logic [QuoWidth-1:0] hi_t_in;
   logic                rej_in;

   logic                         m_valid_ff;
   item_type                     m_item_ff;
   logic                         rej_m_ff;
   logic                         upd_lo_ff;
   logic                         upd_hi_ff;
   logic signed [CoordWidth-1:0] px_lo_ff;
   logic signed [CoordWidth-1:0] py_lo_ff;
   logic signed [CoordWidth-1:0] px_hi_ff;
   logic signed [CoordWidth-1:0] py_hi_ff;
   logic signed [2*QuoWidth-1:0] px_lo_in;
   logic signed [2*QuoWidth-1:0] py_lo_in;
   logic signed [2*QuoWidth-1:0] px_hi_in;
   logic signed [2*QuoWidth-1:0] py_hi_in;

   logic                         out_valid_ff;
   logic                         vis_ff;
   logic signed [CoordWidth-1:0] xa_ff;
   logic signed [CoordWidth-1:0] ya_ff;
   logic signed [CoordWidth-1:0] xb_ff;
   logic signed [CoordWidth-1:0] yb_ff;
   logic                         vis_in;
   logic signed [CoordWidth-1:0] xa_in;
   logic signed [CoordWidth-1:0] ya_in;
   logic signed [CoordWidth-1:0] xb_in;
   logic signed [CoordWidth-1:0] yb_in;

   always_comb begin
      lo_t_in = '0;
      hi_t_in = OneFix;
      rej_in  = item.triv_rej;
      for (int e = 0; e < EdgeCount; e++) begin
         if (!rej_in) begin
            case (item.kind[e])
               EDGE_LOWER: begin
                  if (big[e] || (quo[e] > hi_t_in)) begin
                     rej_in = 1'b1;
                  end else if (quo[e] > lo_t_in) begin
                     lo_t_in = quo[e];
                  end
               end
               EDGE_UPPER: begin
                  if (quo[e] < lo_t_in) begin
                     rej_in = 1'b1;
                  end else if (quo[e] < hi_t_in) begin
                     hi_t_in = quo[e];
                  end
               end
               EDGE_REJECT: rej_in = 1'b1;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      px_lo_in = $signed({1'b0, lo_t_ff}) * t1_item_ff.dx;
      py_lo_in = $signed({1'b0, lo_t_ff}) * t1_item_ff.dy;
      px_hi_in = $signed({1'b0, hi_t_ff}) * t1_item_ff.dx;
      py_hi_in = $signed({1'b0, hi_t_ff}) * t1_item_ff.dy;
   end

   always_comb begin
      logic signed [CoordWidth-1:0] v;
      v      = '0;
      vis_in = m_item_ff.vis;
      xa_in  = m_item_ff.sxa;
      ya_in  = m_item_ff.sya;
      xb_in  = m_item_ff.sxb;
      yb_in  = m_item_ff.syb;
      if (m_item_ff.is_line) begin
         vis_in = !rej_m_ff;
         xa_in  = m_item_ff.xa;
         ya_in  = m_item_ff.ya;
         xb_in  = m_item_ff.xb;
         yb_in  = m_item_ff.yb;
         if (!rej_m_ff) begin
            if (upd_hi_ff) begin
               v = m_item_ff.xa + px_hi_ff;
               xb_in = (v < edge_val(win.right)) ? v : edge_val(win.right);
               v = m_item_ff.ya + py_hi_ff;
               yb_in = (v < edge_val(win.bottom)) ? v : edge_val(win.bottom);
            end
            if (upd_lo_ff) begin
               v = m_item_ff.xa + px_lo_ff;
               xa_in = (v > edge_val(win.left)) ? v : edge_val(win.left);
               v = m_item_ff.ya + py_lo_ff;
               ya_in = (v > edge_val(win.top)) ? v : edge_val(win.top);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff  <= 1'b0;
         m_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         t1_valid_ff  <= in_valid;
         m_valid_ff   <= t1_valid_ff;
         out_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      t1_item_ff <= item;
      lo_t_ff    <= lo_t_in;
      hi_t_ff    <= hi_t_in;
      rej_ff     <= rej_in;
      m_item_ff  <= t1_item_ff;
      rej_m_ff   <= rej_ff;
      upd_lo_ff  <= (lo_t_ff != '0);
      upd_hi_ff  <= (hi_t_ff < OneFix);
      px_lo_ff   <= px_lo_in[2*CoordWidth-1:CoordWidth];
      py_lo_ff   <= py_lo_in[2*CoordWidth-1:CoordWidth];
      px_hi_ff   <= px_hi_in[2*CoordWidth-1:CoordWidth];
      py_hi_ff   <= py_hi_in[2*CoordWidth-1:CoordWidth];
      vis_ff     <= vis_in;
      xa_ff      <= xa_in;
      ya_ff      <= ya_in;
      xb_ff      <= xb_in;
      yb_ff      <= yb_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_visible = vis_ff;
   assign rsp_xa_out  = xa_ff;
   assign rsp_ya_out  = ya_ff;
   assign rsp_xb_out  = xb_ff;
   assign rsp_yb_out  = yb_ff;

   a_params_ordered: assert property (@(posedge clock) disable iff (reset)
      (t1_valid_ff && t1_item_ff.is_line && !rej_ff) |-> (lo_t_ff <= hi_t_ff))
      else $error("line parameters crossed without reject");

   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $past(in_valid, BackLat))
      else $error("result without item");

endmodule

// ===== rtl/clip_window_unit.sv =====
// ----------------------------------------------------------------------------
// clip_window_unit
// Clips points, axis lines, rectangles and arbitrary lines to a window.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_type and req_xa..req_yb with start high; the item is
//   taken at that edge whenever busy is low. busy never rises, so a new item
//   may enter on every clock.
//   Result: rsp_valid rises once the item has passed the entry, divider and back
//   registers, and stays high for one cycle per result, with rsp_visible and the
//   clipped endpoints. Results leave in request order, one per item.
//   Pipeline: 1 entry stage, 17 divider stages (one quotient bit each, four
//   lanes in parallel, one per window edge), 3 back stages. Throughput is
//   one item per clock.
//   Window: csr_we with csr_index (left, top, right, bottom) and csr_wdata
//   writes an edge at once; change it only while no item is in flight.
//   Reset clears all in-flight items and sets the window to 0..1023 on both
//   axes. The receiver cannot stall; results must be taken when shown.
// ----------------------------------------------------------------------------
module clip_window_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [2:0]                            req_type,
   input  logic signed [cwu_pkg::CoordWidth-1:0] req_xa,
   input  logic signed [cwu_pkg::CoordWidth-1:0] req_ya,
   input  logic signed [cwu_pkg::CoordWidth-1:0] req_xb,
   input  logic signed [cwu_pkg::CoordWidth-1:0] req_yb,
   output logic                                  rsp_valid,
   output logic                                  rsp_visible,
   output logic signed [cwu_pkg::CoordWidth-1:0] rsp_xa_out,
   output logic signed [cwu_pkg::CoordWidth-1:0] rsp_ya_out,
   output logic signed [cwu_pkg::CoordWidth-1:0] rsp_xb_out,
   output logic signed [cwu_pkg::CoordWidth-1:0] rsp_yb_out,
   input  logic                                  csr_we,
   input  logic [1:0]                            csr_index,
   input  logic [cwu_pkg::CsrWidth-1:0]          csr_wdata
);
   import cwu_pkg::*;

   window_type win_ff;
   logic       f_valid;
   item_type   f_item;
   logic [EdgeCount-1:0][CoordWidth-1:0] f_num;
   logic [EdgeCount-1:0][CoordWidth-1:0] f_den;
   logic [EdgeCount-1:0][QuoWidth-1:0]   d_quo;
   logic [EdgeCount-1:0]                 d_big;
   item_type dly_item_ff  [DivLat];
   logic     dly_valid_ff [DivLat];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.left   <= '0;
         win_ff.top    <= '0;
         win_ff.right  <= ScreenMaxX;
         win_ff.bottom <= ScreenMaxY;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LEFT:   win_ff.left   <= csr_wdata;
            CSR_TOP:    win_ff.top    <= csr_wdata;
            CSR_RIGHT:  win_ff.right  <= csr_wdata;
            CSR_BOTTOM: win_ff.bottom <= csr_wdata;
            default: ;
         endcase
      end
   end

   cwu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .req_type (req_type),
      .xa       (req_xa),
      .ya       (req_ya),
      .xb       (req_xb),
      .yb       (req_yb),
      .win      (win_ff),
      .valid_ff (f_valid),
      .item_ff  (f_item),
      .num_ff   (f_num),
      .den_ff   (f_den)
   );

   genvar e;
   generate
      for (e = 0; e < EdgeCount; e++) begin : g_div
         cwu_div_lane u_div (
            .clock (clock),
            .num   (f_num[e]),
            .den   (f_den[e]),
            .quo   (d_quo[e]),
            .big   (d_big[e])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DivLat; s++) begin
            dly_valid_ff[s] <= 1'b0;
         end
      end else begin
         dly_valid_ff[0] <= f_valid;
         for (int s = 1; s < DivLat; s++) begin
            dly_valid_ff[s] <= dly_valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      dly_item_ff[0] <= f_item;
      for (int s = 1; s < DivLat; s++) begin
         dly_item_ff[s] <= dly_item_ff[s-1];
      end
   end

   cwu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dly_valid_ff[DivLat-1]),
      .item        (dly_item_ff[DivLat-1]),
      .quo         (d_quo),
      .big         (d_big),
      .win         (win_ff),
      .rsp_valid   (rsp_valid),
      .rsp_visible (rsp_visible),
      .rsp_xa_out  (rsp_xa_out),
      .rsp_ya_out  (rsp_ya_out),
      .rsp_xb_out  (rsp_xb_out),
      .rsp_yb_out  (rsp_yb_out)
   );

   a_result_follows_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, TotalLat))
      else $error("result without accepted item");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

endmodule
